@@ hw/rtl/vpcc_pkg.sv @@
// ----------------------------------------------------------------------------
// vpcc_pkg
// Shared constants, codes and types for the voice playout clock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vpcc_pkg;

  // default timeline width
  localparam int TIME_BITS_DEF = 48;

  // field widths
  localparam int OP_W     = 3;
  localparam int NOW_W    = 48;
  localparam int QUEUED_W = 22;
  localparam int DUR_W    = 16;
  localparam int ACTION_W = 3;
  localparam int LAG_W    = 32;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_BITS  = NOW_W + QUEUED_W + DUR_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ACTION_W + 1 + LAG_W + LAG_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_MS_W   = 16;

  // register reset values
  localparam logic [QUEUED_W-1:0] PREFILL_RST  = QUEUED_W'(3200);
  localparam logic [CFG_MS_W-1:0] PRIME_RST    = CFG_MS_W'(200);
  localparam logic [CFG_MS_W-1:0] CONCEAL_RST  = CFG_MS_W'(500);
  localparam logic [CFG_MS_W-1:0] CATCHUP_RST  = CFG_MS_W'(1000);

  // fixed timing constants
  localparam int UNDERRUN_WINDOW_MS = 1000;
  localparam int BYTES_PER_MS       = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREFILL = 2'd0,
    CFG_PRIME   = 2'd1,
    CFG_CONCEAL = 2'd2,
    CFG_CATCHUP = 2'd3
  } cfg_idx_e_t;

  typedef enum logic [OP_W-1:0] {
    OP_REPRIME = 3'd0,
    OP_ANSWER  = 3'd1,
    OP_AUDIO   = 3'd2,
    OP_READY   = 3'd3,
    OP_EMPTY   = 3'd4,
    OP_FRAME   = 3'd5,
    OP_PLAYED  = 3'd6
  } op_e_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_WAIT    = 3'd1,
    ACT_CONCEAL = 3'd2,
    ACT_DROP    = 3'd3,
    ACT_PLAY    = 3'd4
  } action_e_t;

endpackage

`default_nettype wire

@@ hw/rtl/voice_playout_clock_controller_top.sv @@
// ----------------------------------------------------------------------------
// voice_playout_clock_controller_top
// Playout pacing for a speaker jitter buffer: priming, concealment,
// catch-up drops and lag tracking, one event per word.
// ----------------------------------------------------------------------------
// path: input accept to out_tvalid passes the input register, then the result register
// throughput: one event per cycle while out_tready does not stall; the event logic updates all state in one pass
// backpressure: out_tready low stalls the result register, then the input register
// reset: rst_n synchronous active low; resets all state (priming set), loads register defaults
// no memories, so no clearing pass after reset
`default_nettype none

module voice_playout_clock_controller_top
  import vpcc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // cfg
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: now_ms[47:0], ring_bytes[69:48], duration_ms[85:70], zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: op[2:0]
  input  wire logic [OP_W-1:0]        in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: action[2:0], flag[3], lag_ms[35:4], lag_peak_ms[67:36], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  typedef logic [TIME_BITS-1:0] tm_t;

  localparam tm_t LAG_SAT = TIME_BITS'({LAG_W{1'b1}});

  // config registers
  logic [QUEUED_W-1:0] prefill_r;
  logic [CFG_MS_W-1:0] prime_wait_r;
  logic [CFG_MS_W-1:0] conceal_r;
  logic [CFG_MS_W-1:0] catchup_r;

  // input register
  logic                s1_valid_r;
  logic [OP_W-1:0]     op_r;
  logic [NOW_W-1:0]    now_r;
  logic [QUEUED_W-1:0] queued_r;
  logic [DUR_W-1:0]    dur_r;

  // state
  logic priming_r,  priming_nxt;
  logic armed_r,    armed_nxt;
  tm_t  pstart_r,   pstart_nxt;
  logic ans_over_r, ans_over_nxt;
  logic starve_v_r, starve_v_nxt;
  tm_t  starve_r,   starve_nxt;
  logic tl_v_r,     tl_v_nxt;
  tm_t  tl_start_r, tl_start_nxt;
  tm_t  emitted_r,  emitted_nxt;
  logic wr_seen_r,  wr_seen_nxt;
  tm_t  last_wr_r,  last_wr_nxt;
  logic [LAG_W-1:0] peak_r, peak_nxt;

  // result register
  logic                  out_valid_r;
  logic [ACTION_W-1:0]   action_r, action_nxt;
  logic                  flag_r,   flag_nxt;
  logic [LAG_W-1:0]      lag_r,    lag_nxt;

  logic adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({peak_r, lag_r, flag_r, action_r});

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefill_r    <= PREFILL_RST;
      prime_wait_r <= PRIME_RST;
      conceal_r    <= CONCEAL_RST;
      catchup_r    <= CATCHUP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e_t'(cfg_index))
        CFG_PREFILL: prefill_r    <= cfg_data[QUEUED_W-1:0];
        CFG_PRIME:   prime_wait_r <= cfg_data[CFG_MS_W-1:0];
        CFG_CONCEAL: conceal_r    <= cfg_data[CFG_MS_W-1:0];
        CFG_CATCHUP: catchup_r    <= cfg_data[CFG_MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= in_tuser;
      now_r    <= in_tdata[NOW_W-1:0];
      queued_r <= in_tdata[NOW_W+QUEUED_W-1:NOW_W];
      dur_r    <= in_tdata[NOW_W+QUEUED_W+DUR_W-1:NOW_W+QUEUED_W];
    end
  end

  // ------------------------------------------------------------- lag datapath
  tm_t  now_t, dur_t;
  tm_t  elapsed, late, late_post;
  logic lag_pos, post_pos;
  logic [LAG_W-1:0] lag_pre, lag_post;
  tm_t  em_base;
  logic [TIME_BITS:0] em_sum;
  tm_t  em_add;

  assign now_t = TIME_BITS'(now_r);
  assign dur_t = TIME_BITS'(dur_r);

  assign elapsed   = now_t - tl_start_r;
  assign late      = elapsed - emitted_r;
  assign lag_pos   = tl_v_r && (now_t > tl_start_r) && (elapsed > emitted_r);
  assign lag_pre   = !lag_pos ? '0 : (late > LAG_SAT) ? '1 : late[LAG_W-1:0];

  // lag after the frame length is added to emitted; clamps to 0 when not positive, to all ones above LAG_W bits
  assign late_post = late - dur_t;
  assign post_pos  = lag_pos && (late > dur_t);
  assign lag_post  = !post_pos ? '0 :
                     (late_post > LAG_SAT) ? '1 : late_post[LAG_W-1:0];

  assign em_base = tl_v_r ? emitted_r : '0;
  assign em_sum  = {1'b0, em_base} + {1'b0, dur_t};
  assign em_add  = em_sum[TIME_BITS] ? '1 : em_sum[TIME_BITS-1:0];

  // ------------------------------------------------------------- event logic
  tm_t  start_eff, wait_diff, starve_diff, write_diff;
  logic prime_hold, ready_flag, catch_up, settle;

  assign start_eff   = armed_r ? pstart_r : now_t;
  assign wait_diff   = now_t - start_eff;
  assign prime_hold  = priming_r && (queued_r < prefill_r);
  assign ready_flag  = !(prime_hold &&
                         ((queued_r == '0) || (wait_diff < TIME_BITS'(prime_wait_r))));
  assign starve_diff = now_t - starve_r;
  assign write_diff  = now_t - last_wr_r;
  assign settle      = ans_over_r || (wr_seen_r && (write_diff > TIME_BITS'(conceal_r)));
  assign catch_up    = (lag_pre > LAG_W'(catchup_r)) &&
                       ((queued_r / BYTES_PER_MS) >= QUEUED_W'(catchup_r));

  always_comb begin
    priming_nxt  = priming_r;
    armed_nxt    = armed_r;
    pstart_nxt   = pstart_r;
    ans_over_nxt = ans_over_r;
    starve_v_nxt = starve_v_r;
    starve_nxt   = starve_r;
    tl_v_nxt     = tl_v_r;
    tl_start_nxt = tl_start_r;
    emitted_nxt  = emitted_r;
    wr_seen_nxt  = wr_seen_r;
    last_wr_nxt  = last_wr_r;
    peak_nxt     = peak_r;
    action_nxt   = ACT_NONE;
    flag_nxt     = 1'b0;
    lag_nxt      = lag_pre;

    case (op_e_t'(op_r))
      OP_REPRIME: begin
        priming_nxt  = 1'b1;
        armed_nxt    = 1'b0;
        pstart_nxt   = '0;
        ans_over_nxt = 1'b0;
        tl_v_nxt     = 1'b0;
        tl_start_nxt = '0;
        emitted_nxt  = '0;
        lag_nxt      = '0;
      end
      OP_ANSWER: begin
        ans_over_nxt = 1'b1;
      end
      OP_AUDIO: begin
        if (starve_v_r) begin
          flag_nxt     = starve_diff < TIME_BITS'(UNDERRUN_WINDOW_MS);
          starve_v_nxt = 1'b0;
          starve_nxt   = '0;
        end
        ans_over_nxt = 1'b0;
      end
      OP_READY: begin
        flag_nxt = ready_flag;
        if (ready_flag) begin
          priming_nxt = 1'b0;
          armed_nxt   = 1'b0;
          pstart_nxt  = '0;
        end else if (prime_hold && (queued_r != '0) && !armed_r) begin
          // first queued audio starts the priming wait
          armed_nxt  = 1'b1;
          pstart_nxt = now_t;
        end
      end
      OP_EMPTY: begin
        if (settle) begin
          priming_nxt  = 1'b1;
          armed_nxt    = 1'b0;
          pstart_nxt   = '0;
          ans_over_nxt = 1'b0;
          tl_v_nxt     = 1'b0;
          tl_start_nxt = '0;
          emitted_nxt  = '0;
          lag_nxt      = '0;
          action_nxt   = ACT_WAIT;
        end else begin
          starve_v_nxt = 1'b1;
          starve_nxt   = now_t;
          action_nxt   = ACT_CONCEAL;
        end
      end
      OP_FRAME: begin
        if (catch_up) begin
          emitted_nxt = em_add;
          lag_nxt     = lag_post;
          action_nxt  = ACT_DROP;
        end else begin
          wr_seen_nxt = 1'b1;
          last_wr_nxt = now_t;
          action_nxt  = ACT_PLAY;
        end
      end
      OP_PLAYED: begin
        // a fresh timeline starts at this play time, so its lag is zero
        if (!tl_v_r) begin
          tl_v_nxt     = 1'b1;
          tl_start_nxt = now_t;
        end
        if (lag_pre > peak_r) begin
          peak_nxt = lag_pre;
        end
        emitted_nxt = em_add;
        lag_nxt     = lag_post;
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------- state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      priming_r  <= 1'b1;
      armed_r    <= 1'b0;
      pstart_r   <= '0;
      ans_over_r <= 1'b0;
      starve_v_r <= 1'b0;
      starve_r   <= '0;
      tl_v_r     <= 1'b0;
      tl_start_r <= '0;
      emitted_r  <= '0;
      wr_seen_r  <= 1'b0;
      last_wr_r  <= '0;
      peak_r     <= '0;
    end else if (adv) begin
      priming_r  <= priming_nxt;
      armed_r    <= armed_nxt;
      pstart_r   <= pstart_nxt;
      ans_over_r <= ans_over_nxt;
      starve_v_r <= starve_v_nxt;
      starve_r   <= starve_nxt;
      tl_v_r     <= tl_v_nxt;
      tl_start_r <= tl_start_nxt;
      emitted_r  <= emitted_nxt;
      wr_seen_r  <= wr_seen_nxt;
      last_wr_r  <= last_wr_nxt;
      peak_r     <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      action_r <= action_nxt;
      flag_r   <= flag_nxt;
      lag_r    <= lag_nxt;
    end
  end

  // -------------------------------------------------------------- assertions
  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> peak_r >= $past(peak_r))
    else $error("peak lag decreased");

  a_emitted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tl_v_r |-> emitted_r == '0)
    else $error("emitted total nonzero without a timeline");

  a_armed_priming: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> priming_r)
    else $error("priming wait armed outside priming");

  a_unarmed_start: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> pstart_r == '0)
    else $error("priming start set while not armed");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("event advanced without a result word");

endmodule

`default_nettype wire
